>>> rtl/fes_pkg.sv
// Shared types and constants for the saturating feedback echo core.
package fes_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int DELAY_W   = 16;
	localparam int FILL_W    = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

	localparam logic [FILL_W-1:0] FILL_LIMIT = '1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ECHO_DELAY = 1'b0,
		REG_ECHO_GAIN  = 1'b1
	} cfg_reg_t;

endpackage

>>> rtl/fes_history_ram.sv
// History memory: one write port, one read port with registered read data.
module fes_history_ram
	import fes_pkg::*;
#(
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// write past outputs
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/feedback_echo_saturating_core.sv
// Stages: read and multiply, then mix, then the result register that drives out_sample.
// Throughput: one item per cycle while out_ready holds; at a delay of one the echo loop
// closes through the multiplier and the saturating add, delays of one and two are forwarded.
// A waiting result stalls the input only once both pipeline stages behind it are full.
// Reset: arst_n clears pipeline valids, write pointer and fill count, and sets delay 0,
// gain 16384; the history memory is not cleared and needs no clearing pass.
module feedback_echo_saturating_core
	import fes_pkg::*;
#(
	parameter int MAX_DELAY_DEPTH = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  in_sample,
	input  logic                 clip_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SAMPLE_W-1:0]  out_sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int PW = $clog2(MAX_DELAY_DEPTH);
	localparam int DW = (PW > DELAY_W) ? PW : DELAY_W;
	localparam int CW = (DW > FILL_W) ? DW : FILL_W;
	localparam logic [PW-1:0] PTR_LAST  = PW'(MAX_DELAY_DEPTH - 1);
	localparam logic [PW-1:0] PTR_DEPTH = PW'(MAX_DELAY_DEPTH);
	localparam logic [CW-1:0] DELAY_MAX = CW'(MAX_DELAY_DEPTH - 1);

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	// configuration and sequencing state
	logic [DELAY_W-1:0] echo_delay_q;
	logic [GAIN_W-1:0]  echo_gain_q;
	logic [PW-1:0]      wp_q;
	logic [FILL_W-1:0]  fill_q;

	// pipeline
	logic          s1_valid, s2_valid, out_valid_q;
	sample_t       x_s1, x_s2;
	logic          pass_s1, pass_s2;
	logic          use_x_s1;
	logic [PW-1:0] raddr_s1;
	logic [PW-1:0] waddr_s1, waddr_s2;
	logic          fwd_hit_s1;
	sample_t       fwd_data_s1;
	logic signed [PROD_W-1:0] prod_s2;
	sample_t       out_sample_q;

	logic in_accept, s1_adv, s2_adv, mem_we;
	logic [SAMPLE_W-1:0] mem_rdata;

	// front end signals
	logic [FILL_W-1:0] fill_eff;
	logic [CW-1:0]     d_ext, d_sat_c;
	logic [PW-1:0]     d_sat, raddr_new;
	logic              pass_new, use_x_new;

	// mix signals
	sample_t       src_s1;
	logic signed [GAIN_W:0]   gain_s;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_biased;
	logic signed [PROD_W-16:0] echo_wide;
	sample_t       echo_clamped;
	logic signed [SAMPLE_W:0] sum_wide;
	sample_t       y_mix, y_s2;

	// handshakes
	assign s2_adv    = s2_valid && (!out_valid_q || out_ready);
	assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
	assign in_ready  = !s1_valid || s1_adv;
	assign in_accept = in_valid && in_ready;
	assign mem_we    = s2_adv;
	assign cfg_ready = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	// saturate delay, restart fill on clip start, form read address
	always_comb begin
		fill_eff  = clip_start ? '0 : fill_q;
		d_ext     = CW'(echo_delay_q);
		d_sat_c   = (d_ext > DELAY_MAX) ? DELAY_MAX : d_ext;
		d_sat     = d_sat_c[PW-1:0];
		pass_new  = CW'(fill_eff) < d_sat_c;
		use_x_new = (d_sat_c == '0);
		raddr_new = (wp_q >= d_sat) ? (wp_q - d_sat) : (wp_q + PTR_DEPTH - d_sat);
	end

	// pick echo source: current input, in-flight result, captured write or memory
	always_comb begin
		if (use_x_s1) begin
			src_s1 = x_s1;
		end else if (s2_valid && (waddr_s2 == raddr_s1)) begin
			src_s1 = y_s2;
		end else if (fwd_hit_s1) begin
			src_s1 = fwd_data_s1;
		end else begin
			src_s1 = sample_t'(mem_rdata);
		end
		gain_s  = {1'b0, echo_gain_q};
		prod_s1 = PROD_W'(src_s1) * PROD_W'(gain_s);
	end

	// truncate toward zero, clamp echo, saturating add; pass the input through while filling
	always_comb begin
		prod_biased  = prod_s2 + (prod_s2[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
		echo_wide    = prod_biased[PROD_W-1:15];
		if (echo_wide > $signed((PROD_W-15)'(SAMPLE_MAX))) begin
			echo_clamped = SAMPLE_MAX;
		end else if (echo_wide < (PROD_W-15)'(SAMPLE_MIN)) begin
			echo_clamped = SAMPLE_MIN;
		end else begin
			echo_clamped = echo_wide[SAMPLE_W-1:0];
		end
		sum_wide = {x_s2[SAMPLE_W-1], x_s2} + {echo_clamped[SAMPLE_W-1], echo_clamped};
		if (sum_wide[SAMPLE_W] != sum_wide[SAMPLE_W-1]) begin
			y_mix = sum_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			y_mix = sum_wide[SAMPLE_W-1:0];
		end
		y_s2 = pass_s2 ? x_s2 : y_mix;
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_delay_q <= DELAY_RESET;
			echo_gain_q  <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ECHO_DELAY: echo_delay_q <= cfg_data;
				REG_ECHO_GAIN:  echo_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance write pointer and fill count per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (in_accept) begin
			wp_q   <= ptr_next(wp_q);
			fill_q <= (fill_eff < FILL_LIMIT) ? fill_eff + FILL_W'(1) : fill_eff;
		end
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid <= in_valid;
			end
			if (!s2_valid || s2_adv) begin
				s2_valid <= s1_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= s2_valid;
			end
		end
	end

	// capture stage payloads
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_s1     <= sample_t'(in_sample);
			pass_s1  <= pass_new;
			use_x_s1 <= use_x_new;
			raddr_s1 <= raddr_new;
			waddr_s1 <= wp_q;
		end
		if (s1_adv) begin
			x_s2     <= x_s1;
			pass_s2  <= pass_s1;
			waddr_s2 <= waddr_s1;
			prod_s2  <= prod_s1;
		end
		if (s2_adv) begin
			out_sample_q <= y_s2;
		end
	end

	// hold any write that lands on the pending read address after the read
	always_ff @(posedge clk) begin
		if (in_accept) begin
			fwd_hit_s1  <= mem_we && (waddr_s2 == raddr_new);
			fwd_data_s1 <= y_s2;
		end else if (s1_valid && mem_we && (waddr_s2 == raddr_s1)) begin
			fwd_hit_s1  <= 1'b1;
			fwd_data_s1 <= y_s2;
		end
	end

	fes_history_ram #(
		.DEPTH(MAX_DELAY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s2),
		.wdata (y_s2),
		.re    (in_accept),
		.raddr (raddr_new),
		.rdata (mem_rdata)
	);

`ifndef ASSERT_OFF
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PTR_LAST)
		else $error("write pointer beyond memory depth");

	a_addr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s2_valid) |-> (waddr_s1 == ptr_next(waddr_s2)))
		else $error("in-flight items out of address order");

	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !mem_we)
		else $error("history written while result register stalled");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_valid))
		else $error("result register loaded without a valid item");
`endif

endmodule

>>> dv/tb_feedback_echo_saturating_core.sv
// Self-checking testbench for the saturating feedback echo core.
module tb_feedback_echo_saturating_core
	import fes_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 65536;
	localparam int FILL_MAX     = 131071;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  in_sample;
	logic                 clip_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [SAMPLE_W-1:0]  out_sample;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// echo state as the block should hold it
	logic [SAMPLE_W-1:0] hist_mem [DEPTH];
	int                  hist_wptr;
	int                  clip_fill;
	logic [DELAY_W-1:0]  cur_delay;
	logic [GAIN_W-1:0]   cur_gain;

	sample_t expected_samples[$];
	int      mismatches;
	int      samples_sent;
	bit      calm;
	int      rx_hold;

	feedback_echo_saturating_core #(
		.MAX_DELAY_DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.clip_start(clip_start),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sample(out_sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#(5_000_000);
		$display("tb_feedback_echo_saturating_core: done, errors");
		$finish;
	end

	function automatic sample_t clamp_sample(longint v);
		if (v > longint'(SAMPLE_MAX))
			return SAMPLE_MAX;
		if (v < longint'(SAMPLE_MIN))
			return SAMPLE_MIN;
		return sample_t'(v);
	endfunction

	// advance the echo state by one sample and return the expected output
	function automatic sample_t predict_echo(sample_t x, logic start);
		int      d;
		int      src;
		longint  prod;
		sample_t y;
		d = int'(cur_delay);
		if (d > DEPTH - 1)
			d = DEPTH - 1;
		if (start)
			clip_fill = 0;
		if (clip_fill < d) begin
			y = x;
		end else begin
			if (d == 0)
				src = int'(x);
			else
				src = int'(sample_t'(hist_mem[(hist_wptr + DEPTH - d) % DEPTH]));
			prod = longint'(src) * longint'(cur_gain);
			y = clamp_sample(longint'(x) + longint'(clamp_sample(prod / 32768)));
		end
		hist_mem[hist_wptr] = y;
		hist_wptr = (hist_wptr + 1) % DEPTH;
		if (clip_fill < FILL_MAX)
			clip_fill++;
		return y;
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(0, 64)) - 32);
			3: return sample_t'(int'($urandom_range(0, 4096)) - 2048);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// send one item, record its expected output once it is taken
	task automatic send_sample(sample_t x, logic start);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		in_sample  <= x;
		clip_start <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_samples.push_back(predict_echo(x, start));
		samples_sent++;
	endtask

	// hold the input until every expected output has come, then let the pipe settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ECHO_DELAY: cur_delay = value;
			REG_ECHO_GAIN:  cur_gain  = value;
			default: ;
		endcase
	endtask

	// only called with the block idle
	task automatic set_config(logic [DELAY_W-1:0] delay, logic [GAIN_W-1:0] gain);
		write_reg(REG_ECHO_DELAY, delay);
		write_reg(REG_ECHO_GAIN, gain);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_clip(int len, bit fresh);
		for (int i = 0; i < len; i++)
			send_sample(draw_sample(), (i == 0 && fresh) || ($urandom_range(0, 49) == 0));
	endtask

	task automatic log_mismatch(string what, sample_t want, sample_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// reset values: delay 0, gain one half
	task automatic test_reset_values();
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd3, 1'b1);
		wait_drained();
	endtask

	// zero gain and gain just under two, with no delay
	task automatic test_gain_extremes();
		set_config(16'd0, 16'd0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		wait_drained();
		set_config(16'd0, 16'hffff);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(16'sd20000, 1'b0);
		send_sample(-16'sd1, 1'b0);
		wait_drained();
	endtask

	// one-sample feedback loop driven into saturation, then a clip restart
	task automatic test_feedback_and_restart();
		set_config(16'd1, 16'hffff);
		send_sample(16'sd12000, 1'b1);
		send_sample(16'sd12000, 1'b0);
		send_sample(-16'sd30000, 1'b0);
		send_sample(16'sd5, 1'b0);
		wait_drained();
		set_config(16'd2, 16'd32768);
		send_sample(16'sd1000, 1'b1);
		send_sample(-16'sd2000, 1'b0);
		send_sample(16'sd300, 1'b0);
		send_sample(16'sd7, 1'b1);
		send_sample(16'sd9, 1'b0);
		send_sample(-16'sd4, 1'b0);
		wait_drained();
	endtask

	// a shorter delay takes effect at once within the running clip
	task automatic test_delay_change_mid_clip();
		set_config(16'd3, 16'd16384);
		send_sample(16'sd4000, 1'b1);
		send_sample(-16'sd8000, 1'b0);
		send_sample(16'sd100, 1'b0);
		wait_drained();
		set_config(16'd1, 16'd40000);
		send_sample(16'sd50, 1'b0);
		send_sample(-16'sd50, 1'b0);
		wait_drained();
	endtask

	// largest delay: every sample of a short clip passes straight through
	task automatic test_max_delay();
		set_config(16'hffff, 16'hffff);
		send_clip(12, 1'b1);
		wait_drained();
	endtask

	// random clips over random settings, mostly long enough to reach the echo
	task automatic test_random_clips();
		int                 goal;
		int                 sel;
		int                 nclips;
		int                 len;
		bit                 fresh;
		logic [DELAY_W-1:0] delay;
		logic [GAIN_W-1:0]  gain;
		goal = samples_sent + RANDOM_ITEMS;
		while (samples_sent < goal) begin
			sel = $urandom_range(0, 19);
			if (sel < 12)
				delay = DELAY_W'($urandom_range(0, 8));
			else if (sel < 17)
				delay = DELAY_W'($urandom_range(9, 64));
			else if (sel < 19)
				delay = DELAY_W'($urandom_range(100, 400));
			else
				delay = 16'hffff - DELAY_W'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0: gain = 16'd0;
				1: gain = 16'hffff;
				2: gain = 16'd32768;
				default: gain = GAIN_W'($urandom);
			endcase
			wait_drained();
			calm = ($urandom_range(0, 3) == 0);
			set_config(delay, gain);
			// sometimes keep the running clip so the new delay lands mid-clip
			fresh = ($urandom_range(0, 2) != 0);
			nclips = (delay <= 64) ? int'($urandom_range(1, 3)) : 1;
			for (int c = 0; c < nclips; c++) begin
				len = (delay > 400) ? int'($urandom_range(5, 30))
					: int'(delay) + int'($urandom_range(1, 40));
				send_clip(len, fresh || c != 0);
			end
		end
		calm = 1'b0;
	endtask

	// result side: draw a stall after each taken item
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				if (rx_hold == 1)
					out_ready <= 1'b1;
			end else if (out_valid && out_ready) begin
				int n;
				n = draw_wait();
				if (n != 0) begin
					out_ready <= 1'b0;
					rx_hold   <= n;
				end
			end
		end
	end

	// compare each taken item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sample_t want;
			if (expected_samples.size() == 0) begin
				log_mismatch("unexpected out_sample", '0, sample_t'(out_sample));
			end else begin
				want = expected_samples.pop_front();
				if (sample_t'(out_sample) !== want)
					log_mismatch("out_sample", want, sample_t'(out_sample));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_sample  = '0;
		clip_start = 1'b0;
		out_ready  = 1'b1;
		cfg_valid  = 1'b0;
		cfg_index  = REG_ECHO_DELAY;
		cfg_data   = '0;
		rx_hold    = 0;
		calm       = 1'b0;
		mismatches = 0;
		samples_sent = 0;
		hist_wptr  = 0;
		clip_fill  = 0;
		cur_delay  = DELAY_RESET;
		cur_gain   = GAIN_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_gain_extremes();
		test_feedback_and_restart();
		test_delay_change_mid_clip();
		test_max_delay();
		test_random_clips();

		wait_drained();
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("tb_feedback_echo_saturating_core: done, clean");
		else
			$display("tb_feedback_echo_saturating_core: done, errors");
		$finish;
	end

endmodule
